### sv/assert_macros.svh
// assertion macros shared by the deframer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/edn_pkg.sv
// types and constants of the escaped node tree deframer
`timescale 1ns / 1ps
`default_nettype none

package edn_pkg;

    // result event codes
    typedef enum logic [1:0] {
        EV_OPEN   = 2'd0,
        EV_PROP   = 2'd1,
        EV_CLOSE  = 2'd2,
        EV_STATUS = 2'd3
    } t_event;

    // final status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_ID   = 3'd1,
        ST_SHORT    = 3'd2,
        ST_NO_START = 3'd3,
        ST_TRUNC    = 3'd4,
        ST_NESTING  = 3'd5
    } t_status;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ACCEPTED_ID   = 2'd0,
        CFG_START_MARKER  = 2'd1,
        CFG_END_MARKER    = 2'd2,
        CFG_ESCAPE_MARKER = 2'd3
    } t_cfg_idx;

    // configuration reset values
    localparam logic [31:0] ACCEPTED_ID_RST   = 32'h0000_0000;
    localparam logic [7:0]  START_MARKER_RST  = 8'hFE;
    localparam logic [7:0]  END_MARKER_RST    = 8'hFF;
    localparam logic [7:0]  ESCAPE_MARKER_RST = 8'hFD;

    // header byte positions
    localparam logic [3:0] HDR_ID_LAST   = 4'd3;
    localparam logic [3:0] HDR_START_POS = 4'd4;
    localparam logic [3:0] HDR_ROOT_POS  = 4'd5;
    localparam logic [3:0] HDR_SHORT_MAX = 4'd6;
    localparam logic [3:0] HDR_SAT       = 4'd8;

    // depth counter width: holds one past the largest depth
    localparam int unsigned DEPTH_W = 9;

    // queue between front and back
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;

    // one result item
    typedef struct packed {
        t_event      ev;
        logic [7:0]  node_type;
        logic [7:0]  prop_value;
        logic [7:0]  nest_depth;
        logic        done;
        t_status     status;
    } t_result;

    // front to queue transfer
    typedef struct packed {
        logic    push;
        t_result item;
    } t_res_xfer;

endpackage

`default_nettype wire

### sv/edn_front.sv
// front part: configuration, byte classification and per-file state
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module edn_front
    import edn_pkg::*;
#(
    parameter logic [DEPTH_W-2:0] DEPTH_LIM = 8'd255
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_push,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    input  wire logic        i_q_full,
    output t_res_xfer        o_xfer
);

    // configuration registers
    logic [31:0] r_accepted_id;
    logic [7:0]  r_start_mk;
    logic [7:0]  r_end_mk;
    logic [7:0]  r_esc_mk;

    // per-file state
    logic [3:0]         r_hdr_cnt, n_hdr_cnt;
    logic [31:0]        r_id, n_id;
    logic [DEPTH_W-1:0] r_open, n_open;
    logic               r_in_props, n_in_props;
    logic               r_esc_pend, n_esc_pend;
    logic               r_expect, n_expect;
    t_status            r_err, n_err;

    logic        accept;
    logic        have;
    logic [31:0] id_next;
    t_result     res;
    t_status     st;

    assign accept = i_push && !i_q_full;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accepted_id <= ACCEPTED_ID_RST;
            r_start_mk    <= START_MARKER_RST;
            r_end_mk      <= END_MARKER_RST;
            r_esc_mk      <= ESCAPE_MARKER_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ACCEPTED_ID:   r_accepted_id <= i_cfg_data;
                CFG_START_MARKER:  r_start_mk    <= i_cfg_data[7:0];
                CFG_END_MARKER:    r_end_mk      <= i_cfg_data[7:0];
                CFG_ESCAPE_MARKER: r_esc_mk      <= i_cfg_data[7:0];
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt  <= '0;
            r_id       <= '0;
            r_open     <= '0;
            r_in_props <= 1'b0;
            r_esc_pend <= 1'b0;
            r_expect   <= 1'b0;
            r_err      <= ST_OK;
        end else begin
            r_hdr_cnt  <= n_hdr_cnt;
            r_id       <= n_id;
            r_open     <= n_open;
            r_in_props <= n_in_props;
            r_esc_pend <= n_esc_pend;
            r_expect   <= n_expect;
            r_err      <= n_err;
        end
    end

    // byte classification and result
    always_comb begin
        n_hdr_cnt  = r_hdr_cnt;
        n_id       = r_id;
        n_open     = r_open;
        n_in_props = r_in_props;
        n_esc_pend = r_esc_pend;
        n_expect   = r_expect;
        n_err      = r_err;
        have       = 1'b0;
        id_next    = r_id | ({24'd0, i_data_byte} << {r_hdr_cnt[1:0], 3'b000});
        st         = ST_OK;
        res        = '{ev: EV_OPEN, node_type: 8'd0, prop_value: 8'd0,
                       nest_depth: 8'd0, done: 1'b0, status: ST_OK};

        if (accept) begin
            if (r_hdr_cnt < HDR_SAT) begin
                n_hdr_cnt = r_hdr_cnt + 4'd1;
            end

            if (r_err == ST_OK) begin
                priority if (r_hdr_cnt <= HDR_ID_LAST) begin
                    n_id = id_next;
                    if (r_hdr_cnt == HDR_ID_LAST && id_next != r_accepted_id
                            && id_next != 32'd0) begin
                        n_err = ST_BAD_ID;
                    end
                end else if (r_hdr_cnt == HDR_START_POS) begin
                    if (i_data_byte != r_start_mk) begin
                        n_err = ST_NO_START;
                    end
                end else if (r_hdr_cnt == HDR_ROOT_POS) begin
                    // root type byte, never a marker
                    have           = 1'b1;
                    res.ev         = EV_OPEN;
                    res.node_type  = i_data_byte;
                    n_open         = DEPTH_W'(1);
                    n_in_props     = 1'b1;
                end else if (r_expect) begin
                    n_expect = 1'b0;
                    if (r_open > {1'b0, DEPTH_LIM}) begin
                        n_err = ST_NESTING;
                    end else begin
                        have           = 1'b1;
                        res.ev         = EV_OPEN;
                        res.node_type  = i_data_byte;
                        res.nest_depth = r_open[7:0];
                        n_open         = r_open + DEPTH_W'(1);
                        n_in_props     = 1'b1;
                    end
                end else if (r_esc_pend) begin
                    n_esc_pend = 1'b0;
                    if (r_in_props) begin
                        have           = 1'b1;
                        res.ev         = EV_PROP;
                        res.prop_value = i_data_byte;
                    end
                end else if (i_data_byte == r_start_mk) begin
                    if (r_open == '0) begin
                        n_err = ST_NESTING;
                    end else begin
                        n_in_props = 1'b0;
                        n_expect   = 1'b1;
                    end
                end else if (i_data_byte == r_end_mk) begin
                    if (r_open == '0) begin
                        n_err = ST_NESTING;
                    end else begin
                        n_open         = r_open - DEPTH_W'(1);
                        have           = 1'b1;
                        res.ev         = EV_CLOSE;
                        res.nest_depth = n_open[7:0];
                        n_in_props     = 1'b0;
                    end
                end else if (i_data_byte == r_esc_mk) begin
                    n_esc_pend = 1'b1;
                end else if (r_in_props) begin
                    have           = 1'b1;
                    res.ev         = EV_PROP;
                    res.prop_value = i_data_byte;
                end else begin
                    // plain byte after the first child is dropped
                end
            end

            // final byte: status and clearing of the file state
            if (i_last_byte) begin
                priority if (r_hdr_cnt <= HDR_SHORT_MAX) begin
                    st = ST_SHORT;
                end else if (n_err != ST_OK) begin
                    st = n_err;
                end else if (n_expect || n_esc_pend) begin
                    st = ST_TRUNC;
                end else if (n_open != '0) begin
                    st = ST_NESTING;
                end else begin
                    st = ST_OK;
                end
                if (st != ST_OK || !have) begin
                    res = '{ev: EV_STATUS, node_type: 8'd0, prop_value: 8'd0,
                            nest_depth: 8'd0, done: 1'b0, status: ST_OK};
                end
                res.done   = 1'b1;
                res.status = st;
                n_hdr_cnt  = '0;
                n_id       = '0;
                n_open     = '0;
                n_in_props = 1'b0;
                n_esc_pend = 1'b0;
                n_expect   = 1'b0;
                n_err      = ST_OK;
            end
        end

        o_xfer.push = accept && (have || i_last_byte);
        o_xfer.item = res;
    end

    // checks
    `ASSERT_ALWAYS(a_depth_bound, r_open <= ({1'b0, DEPTH_LIM} + DEPTH_W'(1)), "depth overrun")
    `ASSERT_NEXT(a_last_clears, accept && i_last_byte, r_hdr_cnt == 4'd0 && r_err == ST_OK,
        "file state not cleared after final byte")
    `ASSERT_SAME(a_last_pushes, accept && i_last_byte, o_xfer.push && o_xfer.item.done,
        "final byte gave no done result")

endmodule

`default_nettype wire

### sv/edn_fifo.sv
// short queue of result items between front and back
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module edn_fifo
    import edn_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  t_res_xfer  i_xfer,
    output logic       o_full,
    output logic       o_nempty,
    output t_result    o_head,
    input  wire logic  i_take
);

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr, r_rd;
    logic [FIFO_AW:0]   r_count;
    logic               do_wr, do_rd;

    assign o_full   = (r_count == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_nempty = (r_count != '0);
    assign do_wr    = i_xfer.push && !o_full;
    assign do_rd    = i_take && o_nempty;
    assign o_head   = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr] <= i_xfer.item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wr <= r_wr + FIFO_AW'(1);
            end
            if (do_rd) begin
                r_rd <= r_rd + FIFO_AW'(1);
            end
            unique case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + (FIFO_AW + 1)'(1);
                2'b01:   r_count <= r_count - (FIFO_AW + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // checks
    `ASSERT_ALWAYS(a_count_bound, r_count <= (FIFO_AW + 1)'(FIFO_DEPTH), "queue overfilled")
    `ASSERT_NEXT(a_count_inc, do_wr && !do_rd, r_count == $past(r_count) + (FIFO_AW + 1)'(1),
        "fill count missed a write")

endmodule

`default_nettype wire

### sv/edn_back.sv
// back part: output register that presents the oldest result
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module edn_back
    import edn_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_nempty,
    input  t_result   i_q_head,
    output logic      o_q_take,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_result   o_item
);

    logic    r_valid;
    t_result r_item;
    logic    out_xfer;

    assign out_xfer = i_pop && r_valid;
    assign o_q_take = i_q_nempty && (!r_valid || out_xfer);
    assign o_valid  = r_valid;
    assign o_item   = r_item;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_take) begin
            r_valid <= 1'b1;
        end else if (out_xfer) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_q_take) begin
            r_item <= i_q_head;
        end
    end

    // checks
    `ASSERT_NEXT(a_hold_valid, r_valid && !i_pop, r_valid && $stable(r_item),
        "waiting result lost or changed")

endmodule

`default_nettype wire

### sv/escaped_node_tree_deframer.sv
// top level of the escaped node tree deframer
//
// Usage: file bytes enter on i_data_byte with i_last_byte marking the final
// byte; a byte transfers at a clock edge with push high and full low. Results
// leave as a queue: while empty is low the oldest result sits on the o_ ports
// and transfers at an edge with pop high. Each byte gives zero or one result;
// the final byte always gives one with o_done_res set and o_status valid.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data, one
// register per cycle, while no file is in flight.
// Throughput: one byte per cycle while full is low; the per-byte
// classification and counter update finish in the accept cycle. Path: a
// result is written to the queue at the edge that transfers its byte, then
// moves into the output register once that register is empty or popped.
// Stall: a four-entry queue plus the output register absorb results while
// pop is low; full rises once both are occupied.
// Reset: synchronous, active low; clears queue, output, file state, and
// loads the configuration registers with their defaults.
`timescale 1ns / 1ps
`default_nettype none

module escaped_node_tree_deframer
    import edn_pkg::*;
#(
    parameter int unsigned MAX_DEPTH = 255
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_event_res,
    output logic [7:0]       o_node_type,
    output logic [7:0]       o_prop_value,
    output logic [7:0]       o_nest_depth,
    output logic             o_done_res,
    output logic [2:0]       o_status
);

    // depth limit capped so it fits the depth field
    localparam int unsigned DEPTH_CAP = (MAX_DEPTH > 255) ? 255 : MAX_DEPTH;
    localparam logic [DEPTH_W-2:0] DEPTH_LIM = (DEPTH_W - 1)'(DEPTH_CAP);

    t_res_xfer xfer;
    logic      q_full;
    logic      q_nempty;
    t_result   q_head;
    logic      q_take;
    logic      out_valid;
    t_result   out_item;

    // front: classification and file state
    edn_front #(
        .DEPTH_LIM (DEPTH_LIM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_full    (q_full),
        .o_xfer      (xfer)
    );

    // queue between front and back
    edn_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_xfer   (xfer),
        .o_full   (q_full),
        .o_nempty (q_nempty),
        .o_head   (q_head),
        .i_take   (q_take)
    );

    // back: output register
    edn_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_nempty (q_nempty),
        .i_q_head   (q_head),
        .o_q_take   (q_take),
        .i_pop      (pop),
        .o_valid    (out_valid),
        .o_item     (out_item)
    );

    // result ports
    assign full         = q_full;
    assign empty        = !out_valid;
    assign o_event_res  = out_item.ev;
    assign o_node_type  = out_item.node_type;
    assign o_prop_value = out_item.prop_value;
    assign o_nest_depth = out_item.nest_depth;
    assign o_done_res   = out_item.done;
    assign o_status     = out_item.status;

endmodule

`default_nettype wire
